[rtl/core/tlqe_pkg.sv]
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared types and constants of the thick line quad expander.
// ----------------------------------------------------------------------------
package tlqe_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int FRAC_BITS_DEF   = 4;
   localparam int THICK_WIDTH     = 12;
   localparam int COLOR_WIDTH     = 32;
   localparam int CORNER_WIDTH    = 3;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int MAG_WIDTH       = 16;
   localparam int SQ_WIDTH        = 2 * MAG_WIDTH + 1;
   localparam int SQ_LO_WIDTH     = 17;
   localparam int SQ_HI_WIDTH     = SQ_WIDTH - SQ_LO_WIDTH;
   localparam int A_WIDTH         = MAG_WIDTH + THICK_WIDTH;
   localparam int A2_WIDTH        = 2 * A_WIDTH;
   localparam int Q_WIDTH         = 12;
   localparam int BIT_WIDTH       = 4;
   localparam int K_WIDTH         = Q_WIDTH + 1;
   localparam int K2_WIDTH        = 2 * K_WIDTH;
   localparam int PLO_WIDTH       = K2_WIDTH + SQ_LO_WIDTH;
   localparam int PROD_WIDTH      = K2_WIDTH + SQ_WIDTH;
   localparam int OFS_WIDTH       = Q_WIDTH + 1;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [THICK_WIDTH-1:0] THICK_RESET = 12'd16;
   localparam logic [COLOR_WIDTH-1:0] COLOR_RESET = 32'hFFFF_FFFF;

   localparam logic REG_THICKNESS  = 1'b0;
   localparam logic REG_LINE_COLOR = 1'b1;

   localparam logic [CORNER_WIDTH-1:0] CORNER_C_PLUS   = 3'd0;
   localparam logic [CORNER_WIDTH-1:0] CORNER_C_MINUS  = 3'd1;
   localparam logic [CORNER_WIDTH-1:0] CORNER_N_PLUS   = 3'd2;
   localparam logic [CORNER_WIDTH-1:0] CORNER_C_MINUS2 = 3'd3;
   localparam logic [CORNER_WIDTH-1:0] CORNER_N_PLUS2  = 3'd4;
   localparam logic [CORNER_WIDTH-1:0] CORNER_N_MINUS  = 3'd5;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          transparent;
      logic                          start_of_line;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic [COLOR_WIDTH-1:0]        vertex_color;
      logic [CORNER_WIDTH-1:0]       corner;
      logic                          last_of_run;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic norm_shift;
      logic zero_ofs;
      logic sq_x;
      logic sq_y;
      logic a_mul;
      logic a_sq;
      logic k_sq;
      logic p_lo;
      logic p_hi;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic big;
      logic zero;
      logic bit_zero;
      logic comp;
      logic out_free;
      logic corner_last;
   } sts_type;

endpackage

[rtl/core/tlqe_csr.sv]
// ----------------------------------------------------------------------------
// tlqe_csr
// Configuration registers: thickness and line color, APB-style access.
// ----------------------------------------------------------------------------
module tlqe_csr
   import tlqe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [THICK_WIDTH-1:0]    thickness,
   output logic [COLOR_WIDTH-1:0]    line_color
);

   logic [THICK_WIDTH-1:0] thick_ff, thick_in;
   logic [COLOR_WIDTH-1:0] color_ff, color_in;
   logic                   wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;

   always_comb begin
      thick_in = thick_ff;
      color_in = color_ff;
      if (wr) begin
         case (paddr[2])
            REG_THICKNESS:  thick_in = pwdata[THICK_WIDTH-1:0];
            REG_LINE_COLOR: color_in = pwdata[COLOR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= THICK_RESET;
         color_ff <= COLOR_RESET;
      end else begin
         thick_ff <= thick_in;
         color_ff <= color_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_THICKNESS:  prdata = CSR_DATA_WIDTH'(thick_ff);
         REG_LINE_COLOR: prdata = color_ff;
         default:        prdata = '0;
      endcase
   end

   assign thickness  = thick_ff;
   assign line_color = color_ff;

endmodule

[rtl/core/tlqe_ctrl.sv]
// ----------------------------------------------------------------------------
// tlqe_ctrl
// Sequencer: normalize, squares, bit-serial offset search, six-vertex emit.
// ----------------------------------------------------------------------------
module tlqe_ctrl
   import tlqe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_NORM = 10'b00_0000_0010,
      ST_SQX  = 10'b00_0000_0100,
      ST_SQY  = 10'b00_0000_1000,
      ST_AMUL = 10'b00_0001_0000,
      ST_ASQ  = 10'b00_0010_0000,
      ST_KSQ  = 10'b00_0100_0000,
      ST_PLO  = 10'b00_1000_0000,
      ST_PHI  = 10'b01_0000_0000,
      ST_EMIT = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && sts.go) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (sts.big) begin
               cmd.norm_shift = 1'b1;
            end else if (sts.zero) begin
               cmd.zero_ofs = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_AMUL;
         end
         ST_AMUL: begin
            cmd.a_mul = 1'b1;
            state_in  = ST_ASQ;
         end
         ST_ASQ: begin
            cmd.a_sq = 1'b1;
            state_in = ST_KSQ;
         end
         ST_KSQ: begin
            cmd.k_sq = 1'b1;
            state_in = ST_PLO;
         end
         ST_PLO: begin
            cmd.p_lo = 1'b1;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            cmd.p_hi = 1'b1;
            if (!sts.bit_zero)  state_in = ST_KSQ;
            else if (sts.comp)  state_in = ST_EMIT;
            else                state_in = ST_AMUL;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.corner_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[rtl/core/tlqe_datapath.sv]
// ----------------------------------------------------------------------------
// tlqe_datapath
// Vertex registers, segment offset arithmetic and the result register.
// ----------------------------------------------------------------------------
module tlqe_datapath
   import tlqe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic [THICK_WIDTH-1:0] thickness,
   input  logic [COLOR_WIDTH-1:0] line_color,
   input  cmd_type                cmd,
   output sts_type                sts
);

   localparam logic [THICK_WIDTH:0] THICK_ONE = (THICK_WIDTH+1)'(2**FRAC_BITS);

   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic                          prev_tr_ff, prev_valid_ff;
   logic signed [COORD_WIDTH-1:0] c_x_ff, c_y_ff, n_x_ff, n_y_ff;
   logic signed [DIFF_WIDTH-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic [DIFF_WIDTH-1:0]         mx_ff, my_ff;
   logic [SQ_WIDTH-1:0]           s_ff;
   logic [A_WIDTH-1:0]            a_ff;
   logic [A2_WIDTH-1:0]           a2_ff;
   logic [Q_WIDTH-1:0]            q_ff, t_val, q_nxt;
   logic [BIT_WIDTH-1:0]          bit_ff;
   logic [K2_WIDTH-1:0]           k2_ff;
   logic [K_WIDTH-1:0]            k_val;
   logic [PLO_WIDTH-1:0]          plo_ff;
   logic [PROD_WIDTH-1:0]         prod;
   logic                          comp_ff;
   logic signed [OFS_WIDTH-1:0]   px_ff, py_ff;
   logic [CORNER_WIDTH-1:0]       corner_ff;
   logic                          out_valid_ff;
   rsp_type                       out_ff;
   logic [MAG_WIDTH-1:0]          mx16, my16, msel;
   logic signed [OFS_WIDTH-1:0]   q_pos, q_neg;
   logic                          use_next, use_minus;
   logic signed [COORD_WIDTH-1:0] base_x, base_y, sat_x, sat_y;
   logic signed [DIFF_WIDTH-1:0]  sum_x, sum_y, ofs_x, ofs_y;

   assign dx_in = DIFF_WIDTH'(req_data.x) - DIFF_WIDTH'(prev_x_ff);
   assign dy_in = DIFF_WIDTH'(req_data.y) - DIFF_WIDTH'(prev_y_ff);

   assign mx16  = mx_ff[MAG_WIDTH-1:0];
   assign my16  = my_ff[MAG_WIDTH-1:0];
   assign msel  = comp_ff ? mx16 : my16;
   assign t_val = q_ff | (Q_WIDTH'(1) << bit_ff);
   assign k_val = {t_val, 1'b0} - K_WIDTH'(1);
   assign prod  = (PROD_WIDTH'(k2_ff * s_ff[SQ_WIDTH-1:SQ_LO_WIDTH]) << SQ_LO_WIDTH)
                + PROD_WIDTH'(plo_ff);
   assign q_nxt = (prod <= PROD_WIDTH'(a2_ff)) ? t_val : q_ff;
   assign q_pos = $signed({1'b0, q_nxt});
   assign q_neg = -q_pos;

   assign sts.go = req_data.start_of_line == 1'b0 && req_data.transparent == 1'b0
                && prev_valid_ff && !prev_tr_ff && ({1'b0, thickness} > THICK_ONE);
   assign sts.big         = (mx_ff >> MAG_WIDTH) != '0 || (my_ff >> MAG_WIDTH) != '0;
   assign sts.zero        = mx_ff == '0 && my_ff == '0;
   assign sts.bit_zero    = bit_ff == '0;
   assign sts.comp        = comp_ff;
   assign sts.out_free    = !out_valid_ff || !rsp_stall;
   assign sts.corner_last = corner_ff == CORNER_N_MINUS;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_tr_ff    <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         prev_x_ff     <= req_data.x;
         prev_y_ff     <= req_data.y;
         prev_tr_ff    <= req_data.transparent;
         prev_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         c_x_ff    <= prev_x_ff;
         c_y_ff    <= prev_y_ff;
         n_x_ff    <= req_data.x;
         n_y_ff    <= req_data.y;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         mx_ff     <= dx_in[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx_in) : DIFF_WIDTH'(dx_in);
         my_ff     <= dy_in[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy_in) : DIFF_WIDTH'(dy_in);
         comp_ff   <= 1'b0;
         corner_ff <= CORNER_C_PLUS;
      end
      if (cmd.norm_shift) begin
         mx_ff <= mx_ff >> 1;
         my_ff <= my_ff >> 1;
      end
      if (cmd.zero_ofs) begin
         px_ff <= '0;
         py_ff <= '0;
      end
      if (cmd.sq_x) s_ff <= SQ_WIDTH'(mx16 * mx16);
      if (cmd.sq_y) s_ff <= s_ff + SQ_WIDTH'(my16 * my16);
      if (cmd.a_mul) a_ff <= A_WIDTH'(msel * thickness);
      if (cmd.a_sq) begin
         a2_ff  <= A2_WIDTH'(a_ff * a_ff);
         q_ff   <= '0;
         bit_ff <= BIT_WIDTH'(Q_WIDTH - 1);
      end
      if (cmd.k_sq) k2_ff <= K2_WIDTH'(k_val * k_val);
      if (cmd.p_lo) plo_ff <= PLO_WIDTH'(k2_ff * s_ff[SQ_LO_WIDTH-1:0]);
      if (cmd.p_hi) begin
         q_ff <= q_nxt;
         if (bit_ff == '0) begin
            if (!comp_ff) begin
               px_ff   <= (dy_ff > 0) ? q_neg : q_pos;
               comp_ff <= 1'b1;
            end else begin
               py_ff <= dx_ff[DIFF_WIDTH-1] ? q_neg : q_pos;
            end
         end else begin
            bit_ff <= bit_ff - BIT_WIDTH'(1);
         end
      end
      if (cmd.emit) corner_ff <= corner_ff + CORNER_WIDTH'(1);
   end

   always_comb begin
      case (corner_ff)
         CORNER_C_PLUS:   begin use_next = 1'b0; use_minus = 1'b0; end
         CORNER_C_MINUS:  begin use_next = 1'b0; use_minus = 1'b1; end
         CORNER_N_PLUS:   begin use_next = 1'b1; use_minus = 1'b0; end
         CORNER_C_MINUS2: begin use_next = 1'b0; use_minus = 1'b1; end
         CORNER_N_PLUS2:  begin use_next = 1'b1; use_minus = 1'b0; end
         CORNER_N_MINUS:  begin use_next = 1'b1; use_minus = 1'b1; end
         default:         begin use_next = 1'b0; use_minus = 1'b0; end
      endcase
   end

   assign base_x = use_next ? n_x_ff : c_x_ff;
   assign base_y = use_next ? n_y_ff : c_y_ff;
   assign ofs_x  = use_minus ? -DIFF_WIDTH'(px_ff) : DIFF_WIDTH'(px_ff);
   assign ofs_y  = use_minus ? -DIFF_WIDTH'(py_ff) : DIFF_WIDTH'(py_ff);
   assign sum_x  = DIFF_WIDTH'(base_x) + ofs_x;
   assign sum_y  = DIFF_WIDTH'(base_y) + ofs_y;

   always_comb begin
      sat_x = sum_x[COORD_WIDTH-1:0];
      sat_y = sum_y[COORD_WIDTH-1:0];
      if (sum_x[DIFF_WIDTH-1] != sum_x[COORD_WIDTH-1])
         sat_x = sum_x[DIFF_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      if (sum_y[DIFF_WIDTH-1] != sum_y[COORD_WIDTH-1])
         sat_y = sum_y[DIFF_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff.out_x        <= sat_x;
         out_ff.out_y        <= sat_y;
         out_ff.vertex_color <= line_color;
         out_ff.corner       <= corner_ff;
         out_ff.last_of_run  <= corner_ff == CORNER_N_MINUS;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.last_of_run |-> out_ff.corner == CORNER_N_MINUS)
      else $error("last_of_run on wrong corner");
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.corner <= CORNER_N_MINUS)
      else $error("corner out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !out_valid_ff || !rsp_stall)
      else $error("result register overwritten");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result valid after reset");
`endif

endmodule

[rtl/core/thick_line_quad_expander.sv]
// ----------------------------------------------------------------------------
// thick_line_quad_expander
// Expands polyline segments into two triangles offset by half the thickness.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  req       req_valid/req_stall  req_type: x, y, transparent, start_of_line
//  rsp       rsp_valid/rsp_stall  rsp_type: out_x, out_y, vertex_color, ...
//  csr       psel/penable/pready  thickness at 0x0, line_color at 0x4
//
//  a vertex giving no triangles is accepted in idle; a zero-length segment goes
//  from normalize to emit; an expanded segment runs setup, each offset component
//  (bit-serial reciprocal-root search, one quotient bit per pass), then emit
//  synchronous reset clears state to no previous vertex, registers to defaults
//  a stalled result holds the emit; the next request waits in idle only
// ----------------------------------------------------------------------------
module thick_line_quad_expander
   import tlqe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [THICK_WIDTH-1:0] thickness;
   logic [COLOR_WIDTH-1:0] line_color;
   cmd_type                cmd;
   sts_type                sts;

   tlqe_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .thickness  (thickness),
      .line_color (line_color)
   );

   tlqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlqe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .thickness  (thickness),
      .line_color (line_color),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
